>>> src/cmds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmds_pkg: shared types and constants of the circle delta span generator
// configuration register map, queue entry layout and square root sizes
// ----------------------------------------------------------------------------
package cmds_pkg;

    localparam int ROW_W      = 12;
    localparam int DIM_W      = 13;
    localparam int POS_W      = 15;
    localparam int RAD_W      = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;
    localparam int S_DATA_W   = 16;
    localparam int M_DATA_W   = 40;

    // square root of a 28 bit radicand, one result bit per step
    localparam int SQ_W       = 2 * RAD_W;
    localparam int SQRT_STEPS = RAD_W;

    localparam int FIFO_DEPTH = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH   = 3'd0,
        REG_HEIGHT  = 3'd1,
        REG_OLD_CX  = 3'd2,
        REG_OLD_CY  = 3'd3,
        REG_OLD_RAD = 3'd4,
        REG_NEW_CX  = 3'd5,
        REG_NEW_CY  = 3'd6,
        REG_NEW_RAD = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic        [DIM_W-1:0] width;
        logic        [DIM_W-1:0] height;
        logic signed [POS_W-1:0] old_cx;
        logic signed [POS_W-1:0] old_cy;
        logic        [RAD_W-1:0] old_rad;
        logic signed [POS_W-1:0] new_cx;
        logic signed [POS_W-1:0] new_cy;
        logic        [RAD_W-1:0] new_rad;
    } cfg_t;

    // one classified row waiting for the back end
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic             has_old;
        logic             has_new;
        logic [RAD_W-1:0] dy_old;
        logic [RAD_W-1:0] dy_new;
    } job_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fifo_stat_t;

endpackage : cmds_pkg
`default_nettype wire

>>> src/cmds_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmds_front: row intake and classification
// takes row beats, drops rows outside the picture or touching neither circle
// and queues the rest with the vertical distance to each circle center
// ----------------------------------------------------------------------------
module cmds_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire cmds_pkg::cfg_t                cfg,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [cmds_pkg::S_DATA_W-1:0] s_tdata,   // [11:0] row_index
    input  wire cmds_pkg::fifo_stat_t          fifo_stat,
    output logic                               fifo_push,
    output cmds_pkg::job_t                     fifo_wdata
);
    import cmds_pkg::*;

    logic             fr_valid_reg;
    logic [ROW_W-1:0] fr_row_reg;

    logic signed [15:0] row_s;
    logic signed [15:0] dy_old;
    logic signed [15:0] dy_new;
    logic        [15:0] ady_old;
    logic        [15:0] ady_new;
    logic               in_old;
    logic               in_new;
    logic               keep;
    logic               consume;

    always_comb begin
        row_s   = $signed({4'b0, fr_row_reg});
        dy_old  = row_s - $signed({cfg.old_cy[POS_W-1], cfg.old_cy});
        dy_new  = row_s - $signed({cfg.new_cy[POS_W-1], cfg.new_cy});
        ady_old = dy_old[15] ? 16'(-dy_old) : 16'(dy_old);
        ady_new = dy_new[15] ? 16'(-dy_new) : 16'(dy_new);
        in_old  = (cfg.old_rad != '0) && (ady_old <= {2'b0, cfg.old_rad});
        in_new  = (cfg.new_rad != '0) && (ady_new <= {2'b0, cfg.new_rad});
        keep    = (cfg.width != '0) && ({1'b0, fr_row_reg} < cfg.height)
                  && (in_old || in_new);
    end

    assign consume   = fr_valid_reg && (!keep || !fifo_stat.full);
    assign fifo_push = fr_valid_reg && keep && !fifo_stat.full;
    assign s_tready  = !fr_valid_reg || consume;

    assign fifo_wdata.row     = fr_row_reg;
    assign fifo_wdata.has_old = in_old;
    assign fifo_wdata.has_new = in_new;
    assign fifo_wdata.dy_old  = ady_old[RAD_W-1:0];
    assign fifo_wdata.dy_new  = ady_new[RAD_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fr_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            fr_valid_reg <= 1'b1;
        end else if (consume) begin
            fr_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            fr_row_reg <= s_tdata[ROW_W-1:0];
        end
    end

endmodule : cmds_front
`default_nettype wire

>>> src/cmds_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmds_fifo: short queue of classified rows
// decouples the intake from the span engine
// ----------------------------------------------------------------------------
module cmds_fifo (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire cmds_pkg::job_t       wdata,
    input  wire logic                 pop,
    output cmds_pkg::job_t            rdata,
    output cmds_pkg::fifo_stat_t      stat
);
    import cmds_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    job_t             mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
    endfunction

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_W'(FIFO_DEPTH));
    assign rdata      = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule : cmds_fifo
`default_nettype wire

>>> src/cmds_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmds_isqrt: iterative integer square root
// restoring digit recurrence, one result bit per clock
// ----------------------------------------------------------------------------
module cmds_isqrt (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            start,
    input  wire logic [cmds_pkg::SQ_W-1:0]       radicand,
    output logic                                 done,
    output logic [cmds_pkg::SQRT_STEPS-1:0]      root
);
    import cmds_pkg::*;

    localparam int CNT_W = $clog2(SQRT_STEPS);
    localparam int REM_W = SQRT_STEPS + 1;

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [SQ_W-1:0]       val_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [SQRT_STEPS-1:0] root_reg;

    logic [REM_W+1:0] rem_t;
    logic [REM_W+1:0] trial;
    logic             ge;

    always_comb begin
        rem_t = {rem_reg, val_reg[SQ_W-1 -: 2]};
        trial = {1'b0, root_reg, 2'b01};
        ge    = (rem_t >= trial);
    end

    assign done = done_reg;
    assign root = root_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            val_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            val_reg  <= {val_reg[SQ_W-3:0], 2'b00};
            rem_reg  <= ge ? REM_W'(rem_t - trial) : rem_t[REM_W-1:0];
            root_reg <= {root_reg[SQRT_STEPS-2:0], ge};
        end
    end

endmodule : cmds_isqrt
`default_nettype wire

>>> src/cmds_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmds_back: span engine
// squares, two parallel square roots, clamping, span differences and beat
// emission through the output register
// ----------------------------------------------------------------------------
module cmds_back #(
    parameter int MAX_DIM = 4096
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire cmds_pkg::cfg_t                cfg,
    input  wire cmds_pkg::fifo_stat_t          fifo_stat,
    input  wire cmds_pkg::job_t                fifo_rdata,
    output logic                               fifo_pop,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [cmds_pkg::M_DATA_W-1:0]      m_tdata,  // [11:0] span_row, [23:12] start_col,
                                                         // [36:24] span_len, [39:37] zero
    output logic                               m_tuser,  // [0] from_foreground
    output logic                               m_tlast   // last_span
);
    import cmds_pkg::*;

    localparam logic [14:0] MAX_DIM_W = 15'(MAX_DIM);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUB,
        ST_SQRT,
        ST_CLAMP,
        ST_SPAN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic             valid;
        logic [DIM_W-1:0] start;
        logic [DIM_W-1:0] len;
    } span_t;

    state_t               state_reg, state_next;
    logic                 m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0]  m_data_reg, m_data_next;
    logic                 m_user_reg, m_user_next;
    logic                 m_last_reg, m_last_next;
    logic [3:0]           pend_reg, pend_next;

    job_t                 job_reg;
    logic [SQ_W-1:0]      rsq_old_reg, rsq_new_reg;
    logic [SQ_W-1:0]      dsq_old_reg, dsq_new_reg;
    logic [DIM_W-1:0]     o1_reg, o2_reg, n1_reg, n2_reg;
    span_t                cand_reg [4];
    span_t                cand_next [4];

    logic [SQ_W-1:0]      rad_old_v, rad_new_v;
    logic                 sq_start;
    logic                 done_old, done_new;
    logic [RAD_W-1:0]     s_old, s_new;
    logic [DIM_W-1:0]     w_eff, w_max;
    logic signed [16:0]   o_lo, o_hi, n_lo, n_hi;
    logic [1:0]           sel;
    logic [3:0]           pend_left;
    logic                 out_free;
    span_t                sel_span;

    function automatic logic [DIM_W-1:0] clamp_col(input logic signed [16:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        if (v[16]) begin
            r = '0;
        end else if (v[15:0] > {3'b0, hi}) begin
            r = hi;
        end else begin
            r = v[DIM_W-1:0];
        end
        return r;
    endfunction

    function automatic logic no_overlap(input logic has_b,
                                        input logic [DIM_W-1:0] a1, input logic [DIM_W-1:0] a2,
                                        input logic [DIM_W-1:0] b1, input logic [DIM_W-1:0] b2);
        return !has_b || (a2 < b1) || (a1 > b2);
    endfunction

    // part of span a left of span b, or all of a when they do not meet
    function automatic span_t left_part(input logic has_a, input logic has_b,
                                        input logic [DIM_W-1:0] a1, input logic [DIM_W-1:0] a2,
                                        input logic [DIM_W-1:0] b1, input logic [DIM_W-1:0] b2);
        span_t sp;
        logic  apart;
        apart    = no_overlap(has_b, a1, a2, b1, b2);
        sp.valid = has_a && (apart || (a1 < b1));
        sp.start = a1;
        sp.len   = apart ? DIM_W'(a2 - a1 + 1'b1) : DIM_W'(b1 - a1);
        return sp;
    endfunction

    function automatic span_t right_part(input logic has_a, input logic has_b,
                                         input logic [DIM_W-1:0] a1, input logic [DIM_W-1:0] a2,
                                         input logic [DIM_W-1:0] b1, input logic [DIM_W-1:0] b2);
        span_t sp;
        logic  apart;
        apart    = no_overlap(has_b, a1, a2, b1, b2);
        sp.valid = has_a && !apart && (a2 > b2);
        sp.start = DIM_W'(b2 + 1'b1);
        sp.len   = DIM_W'(a2 - b2);
        return sp;
    endfunction

    function automatic logic [1:0] lowest(input logic [3:0] p);
        logic [1:0] r;
        if (p[0]) begin
            r = 2'd0;
        end else if (p[1]) begin
            r = 2'd1;
        end else if (p[2]) begin
            r = 2'd2;
        end else begin
            r = 2'd3;
        end
        return r;
    endfunction

    cmds_isqrt u_sqrt_old (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand (rad_old_v),
        .done     (done_old),
        .root     (s_old)
    );

    cmds_isqrt u_sqrt_new (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand (rad_new_v),
        .done     (done_new),
        .root     (s_new)
    );

    assign fifo_pop  = (state_reg == ST_IDLE) && !fifo_stat.empty;
    assign sq_start  = (state_reg == ST_SUB);
    assign rad_old_v = rsq_old_reg - dsq_old_reg;
    assign rad_new_v = rsq_new_reg - dsq_new_reg;

    always_comb begin
        w_eff = ({2'b0, cfg.width} > MAX_DIM_W) ? MAX_DIM_W[DIM_W-1:0] : cfg.width;
        w_max = w_eff - 1'b1;
        o_lo  = $signed({{2{cfg.old_cx[POS_W-1]}}, cfg.old_cx}) - $signed({3'b0, s_old});
        o_hi  = $signed({{2{cfg.old_cx[POS_W-1]}}, cfg.old_cx}) + $signed({3'b0, s_old});
        n_lo  = $signed({{2{cfg.new_cx[POS_W-1]}}, cfg.new_cx}) - $signed({3'b0, s_new});
        n_hi  = $signed({{2{cfg.new_cx[POS_W-1]}}, cfg.new_cx}) + $signed({3'b0, s_new});
    end

    // candidate spans: background left/right of the new span, then foreground
    always_comb begin
        cand_next[0] = left_part(job_reg.has_old, job_reg.has_new, o1_reg, o2_reg, n1_reg, n2_reg);
        cand_next[1] = right_part(job_reg.has_old, job_reg.has_new, o1_reg, o2_reg, n1_reg, n2_reg);
        cand_next[2] = left_part(job_reg.has_new, job_reg.has_old, n1_reg, n2_reg, o1_reg, o2_reg);
        cand_next[3] = right_part(job_reg.has_new, job_reg.has_old, n1_reg, n2_reg, o1_reg, o2_reg);
    end

    always_comb begin
        out_free  = !m_valid_reg || m_tready;
        sel       = lowest(pend_reg);
        sel_span  = cand_reg[sel];
        pend_left = pend_reg & ~(4'b0001 << sel);

        state_next   = state_reg;
        pend_next    = pend_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        m_last_next  = m_last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (!fifo_stat.empty) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_SUB;
            end
            ST_SUB: begin
                state_next = ST_SQRT;
            end
            ST_SQRT: begin
                if (done_old && done_new) begin
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP: begin
                state_next = ST_SPAN;
            end
            ST_SPAN: begin
                state_next = ST_EMIT;
                pend_next  = {cand_next[3].valid, cand_next[2].valid,
                              cand_next[1].valid, cand_next[0].valid};
            end
            ST_EMIT: begin
                if (pend_reg == '0) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {3'b0, sel_span.len, sel_span.start[ROW_W-1:0], job_reg.row};
                    m_user_next  = sel[1];
                    m_last_next  = (pend_left == '0);
                    pend_next    = pend_left;
                    if (pend_left == '0) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            pend_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            pend_reg    <= pend_next;
        end
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        m_last_reg <= m_last_next;
    end

    always_ff @(posedge aclk) begin
        if (fifo_pop) begin
            job_reg <= fifo_rdata;
        end
        if (state_reg == ST_MUL) begin
            rsq_old_reg <= {{RAD_W{1'b0}}, cfg.old_rad} * {{RAD_W{1'b0}}, cfg.old_rad};
            rsq_new_reg <= {{RAD_W{1'b0}}, cfg.new_rad} * {{RAD_W{1'b0}}, cfg.new_rad};
            dsq_old_reg <= {{RAD_W{1'b0}}, job_reg.dy_old} * {{RAD_W{1'b0}}, job_reg.dy_old};
            dsq_new_reg <= {{RAD_W{1'b0}}, job_reg.dy_new} * {{RAD_W{1'b0}}, job_reg.dy_new};
        end
        if (state_reg == ST_CLAMP) begin
            o1_reg <= clamp_col(o_lo, w_max);
            o2_reg <= clamp_col(o_hi, w_max);
            n1_reg <= clamp_col(n_lo, w_max);
            n2_reg <= clamp_col(n_hi, w_max);
        end
        if (state_reg == ST_SPAN) begin
            cand_reg <= cand_next;
        end
    end

endmodule : cmds_back
`default_nettype wire

>>> src/circle_mask_delta_spans.sv
// Circle mask delta span generator.
// Input channel s_*: one beat per screen row, row index in s_tdata[11:0].
// Output channel m_*: up to four copy spans per row. m_tuser is 0 for a span
// copied from the background (inside the old circle only) and 1 for a span
// copied from the foreground (inside the new circle only); m_tlast marks the
// final span of a row. Rows outside the picture or with identical spans give
// no beats at all.
// Configuration channel cfg_*: register index and data, always ready; write
// it only while no row is in flight.
// The spans of a row follow back to back while the receiver is ready; the
// span engine takes one row at a time, paced by its two 14 step square root
// units. Rows that touch neither circle or lie outside the picture are
// dropped at intake, one per cycle.
// A two entry queue sits between intake and span engine, so rows are taken
// while the engine and the output register are busy; when the receiver
// stalls, the output register holds its beat and the queue then fills.
// Reset loads the register defaults (800 x 480, both radii zero) and clears
// the queue and all valid flags.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// circle_mask_delta_spans: top level
// configuration registers, intake, queue and span engine
// ----------------------------------------------------------------------------
module circle_mask_delta_spans #(
    parameter int MAX_DIM = 4096
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [cmds_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [cmds_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [cmds_pkg::S_DATA_W-1:0]        s_tdata,  // [11:0] row_index
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [cmds_pkg::M_DATA_W-1:0]             m_tdata,  // [11:0] span_row,
                                                                // [23:12] start_col,
                                                                // [36:24] span_len
    output logic                                      m_tuser,  // [0] from_foreground
    output logic                                      m_tlast   // last_span
);
    import cmds_pkg::*;

    cfg_t       cfg_reg;
    job_t       fifo_wdata;
    job_t       fifo_rdata;
    fifo_stat_t fifo_stat;
    logic       fifo_push;
    logic       fifo_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.width   <= DIM_W'(800);
            cfg_reg.height  <= DIM_W'(480);
            cfg_reg.old_cx  <= '0;
            cfg_reg.old_cy  <= '0;
            cfg_reg.old_rad <= '0;
            cfg_reg.new_cx  <= '0;
            cfg_reg.new_cy  <= '0;
            cfg_reg.new_rad <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_WIDTH:   cfg_reg.width   <= cfg_data[DIM_W-1:0];
                REG_HEIGHT:  cfg_reg.height  <= cfg_data[DIM_W-1:0];
                REG_OLD_CX:  cfg_reg.old_cx  <= $signed(cfg_data[POS_W-1:0]);
                REG_OLD_CY:  cfg_reg.old_cy  <= $signed(cfg_data[POS_W-1:0]);
                REG_OLD_RAD: cfg_reg.old_rad <= cfg_data[RAD_W-1:0];
                REG_NEW_CX:  cfg_reg.new_cx  <= $signed(cfg_data[POS_W-1:0]);
                REG_NEW_CY:  cfg_reg.new_cy  <= $signed(cfg_data[POS_W-1:0]);
                REG_NEW_RAD: cfg_reg.new_rad <= cfg_data[RAD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    cmds_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .fifo_stat  (fifo_stat),
        .fifo_push  (fifo_push),
        .fifo_wdata (fifo_wdata)
    );

    cmds_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (fifo_push),
        .wdata   (fifo_wdata),
        .pop     (fifo_pop),
        .rdata   (fifo_rdata),
        .stat    (fifo_stat)
    );

    cmds_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .fifo_stat  (fifo_stat),
        .fifo_rdata (fifo_rdata),
        .fifo_pop   (fifo_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

`ifndef ASSERT_OFF
    // intake never writes a full queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_push |-> !fifo_stat.full)
        else $error("row queue overflow");

    // engine never reads an empty queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_pop |-> !fifo_stat.empty)
        else $error("row queue underflow");

    // every span covers at least one pixel
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[36:24] != '0))
        else $error("empty span emitted");

    // spans only for rows inside the picture
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ({1'b0, m_tdata[11:0]} < cfg_reg.height))
        else $error("span for row outside the picture");
`endif

endmodule : circle_mask_delta_spans
`default_nettype wire
